>>> src/fpt_pkg.sv
// Shared types, constants and register codes for the fingerprint parameter tuner.
`timescale 1ns / 1ps
package fpt_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_INDEX_W-1:0] REG_RECALL_LOW = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RECALL_HIGH = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LATENCY_HIGH = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LATENCY_LOW = 4'd3;

   localparam logic [63:0] HASH_SEED = 64'd5381;

   localparam logic [16:0] RECALL_LOW_RESET = 17'd58982;
   localparam logic [16:0] RECALL_HIGH_RESET = 17'd64881;
   localparam logic [15:0] LATENCY_HIGH_RESET = 16'd100;
   localparam logic [15:0] LATENCY_LOW_RESET = 16'd15;

   localparam logic [8:0] EF_DEFAULT = 9'd32;
   localparam logic [6:0] BEAM_DEFAULT = 7'd8;

   // tuning math runs one bit wider than the stored fields
   localparam logic [9:0] EF_STEP = 10'd8;
   localparam logic [9:0] EF_GROW_BELOW = 10'd128;
   localparam logic [9:0] EF_SHRINK_ABOVE = 10'd24;
   localparam logic [9:0] EF_MIN = 10'd8;
   localparam logic [9:0] EF_MAX = 10'd256;
   localparam logic [7:0] BEAM_STEP = 8'd2;
   localparam logic [7:0] BEAM_SHRINK_ABOVE = 8'd4;
   localparam logic [7:0] BEAM_GROW_BELOW = 8'd32;
   localparam logic [7:0] BEAM_MIN = 8'd2;
   localparam logic [7:0] BEAM_MAX = 8'd64;

   typedef struct packed {
      logic [7:0] text_byte;
      logic last_byte;
      logic [16:0] recall;
      logic [15:0] latency;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] fingerprint;
      logic was_found;
      logic table_full;
      logic [31:0] times_seen;
      logic [8:0] search_breadth;
      logic [6:0] beam_width;
   } rsp_payload_type;

   typedef struct packed {
      logic [63:0] fingerprint;
      logic [16:0] recall;
      logic [15:0] latency;
   } job_type;

   typedef struct packed {
      logic [16:0] recall_low;
      logic [16:0] recall_high;
      logic [15:0] latency_high;
      logic [15:0] latency_low;
   } cfg_type;

   typedef struct packed {
      logic [63:0] key;
      logic [31:0] seen;
      logic [8:0] ef;
      logic [6:0] beam;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

>>> src/fpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/fpt_queue.sv
// Short job queue between the hashing front and the table back end.
`timescale 1ns / 1ps
module fpt_queue
   import fpt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  job_type push_data,
   input  logic pop,
   output logic full,
   output logic empty,
   output job_type head
);

   job_type slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/fpt_hash.sv
// Front end: folds text bytes into the djb2 fingerprint and emits one job per query.
`timescale 1ns / 1ps
module fpt_hash
   import fpt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   input  req_payload_type req_data,
   input  logic queue_full,
   output logic job_push,
   output job_type job_data
);

   logic [63:0] acc_ff, acc_in;
   logic [63:0] acc_next;
   logic accept;

   assign accept = req_push && !queue_full;
   // h * 33 + byte
   assign acc_next = (acc_ff << 5) + acc_ff + {56'd0, req_data.text_byte};

   assign job_push = accept && req_data.last_byte;
   assign job_data.fingerprint = acc_next;
   assign job_data.recall = req_data.recall;
   assign job_data.latency = req_data.latency;

   always_comb begin
      acc_in = acc_ff;
      if (accept) begin
         acc_in = req_data.last_byte ? HASH_SEED : acc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= HASH_SEED;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

>>> src/fpt_table.sv
// Back end: scans the fingerprint table, tunes or inserts the entry (or flags a full table), holds the result.
`timescale 1ns / 1ps
module fpt_table
   import fpt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  cfg_type cfg,
   input  logic job_empty,
   input  job_type job_head,
   output logic job_pop,
   input  logic rsp_pop,
   output logic rsp_empty,
   output rsp_payload_type rsp_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0] state_ff, state_in;
   job_type job_ff, job_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic issue_ff, issue_in;
   logic chk_ff, chk_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   entry_type hit_entry_ff, hit_entry_in;
   logic free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic ram_rd_en;
   entry_type ram_rd_data;
   logic ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   entry_type ram_wr_data;

   logic out_free;
   logic chk_valid;
   logic [9:0] ef_a, ef_b, ef_c;
   logic [7:0] beam_a, beam_c;
   logic [31:0] seen_new;
   rsp_payload_type result;

   fpt_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_entry_ram (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en(ram_rd_en),
      .rd_addr(idx_ff),
      .rd_data(ram_rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_pop;
   assign chk_valid = valid_ff[chk_idx_ff];
   assign ram_rd_en = (state_ff == ST_SCAN) && issue_ff;

   // tuning of a hit entry
   always_comb begin
      ef_a = {1'b0, hit_entry_ff.ef};
      if (job_ff.recall < cfg.recall_low && ef_a < EF_GROW_BELOW) begin
         ef_a = ef_a + EF_STEP;
      end
      ef_b = ef_a;
      if (job_ff.recall > cfg.recall_high && ef_b > EF_SHRINK_ABOVE) begin
         ef_b = ef_b - EF_STEP;
      end
      ef_c = (ef_b < EF_MIN) ? EF_MIN : ((ef_b > EF_MAX) ? EF_MAX : ef_b);

      beam_a = {1'b0, hit_entry_ff.beam};
      if (job_ff.latency > cfg.latency_high && beam_a > BEAM_SHRINK_ABOVE) begin
         beam_a = beam_a - BEAM_STEP;
      end else if (job_ff.latency < cfg.latency_low && beam_a < BEAM_GROW_BELOW) begin
         beam_a = beam_a + BEAM_STEP;
      end
      beam_c = (beam_a < BEAM_MIN) ? BEAM_MIN : ((beam_a > BEAM_MAX) ? BEAM_MAX : beam_a);

      seen_new = (hit_entry_ff.seen == '1) ? hit_entry_ff.seen : hit_entry_ff.seen + 32'd1;
   end

   always_comb begin
      result.fingerprint = job_ff.fingerprint;
      result.was_found = 1'b0;
      result.table_full = 1'b0;
      result.times_seen = 32'd0;
      result.search_breadth = EF_DEFAULT;
      result.beam_width = BEAM_DEFAULT;
      ram_wr_data.key = job_ff.fingerprint;
      ram_wr_data.seen = 32'd1;
      ram_wr_data.ef = EF_DEFAULT;
      ram_wr_data.beam = BEAM_DEFAULT;
      ram_wr_addr = free_idx_ff;
      if (hit_ff) begin
         result.was_found = 1'b1;
         result.times_seen = seen_new;
         result.search_breadth = ef_c[8:0];
         result.beam_width = beam_c[6:0];
         ram_wr_data.seen = seen_new;
         ram_wr_data.ef = ef_c[8:0];
         ram_wr_data.beam = beam_c[6:0];
         ram_wr_addr = hit_idx_ff;
      end else if (free_ff) begin
         result.times_seen = 32'd1;
      end else begin
         result.table_full = 1'b1;
      end
   end

   assign ram_wr_en = (state_ff == ST_UPDATE) && out_free && (hit_ff || free_ff);

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      idx_in = idx_ff;
      issue_in = issue_ff;
      chk_in = 1'b0;
      chk_idx_in = idx_ff;
      hit_in = hit_ff;
      hit_idx_in = hit_idx_ff;
      hit_entry_in = hit_entry_ff;
      free_in = free_ff;
      free_idx_in = free_idx_ff;
      valid_in = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_data_in = rsp_data_ff;
      job_pop = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop = 1'b1;
               job_in = job_head;
               idx_in = '0;
               issue_in = 1'b1;
               hit_in = 1'b0;
               free_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            chk_in = issue_ff;
            if (issue_ff) begin
               if (idx_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
                  issue_in = 1'b0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            if (chk_ff) begin
               if (chk_valid) begin
                  if (ram_rd_data.key == job_ff.fingerprint) begin
                     hit_in = 1'b1;
                     hit_idx_in = chk_idx_ff;
                     hit_entry_in = ram_rd_data;
                     state_in = ST_UPDATE;
                  end
               end else if (!free_ff) begin
                  free_in = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
               if (!issue_ff) begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = result;
               if (!hit_ff && free_ff) begin
                  valid_in[free_idx_ff] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         issue_ff <= 1'b0;
         chk_ff <= 1'b0;
         hit_ff <= 1'b0;
         free_ff <= 1'b0;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         chk_ff <= chk_in;
         hit_ff <= hit_in;
         free_ff <= free_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      idx_ff <= idx_in;
      chk_idx_ff <= chk_idx_in;
      hit_idx_ff <= hit_idx_in;
      hit_entry_ff <= hit_entry_in;
      free_idx_ff <= free_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

>>> src/fingerprint_param_tuner_core.sv
// Top level of the fingerprint parameter tuner: registers, front, queue and back end.
//
//   channel   ports                                   transaction when
//   request   req_push, req_full, req_data            req_push && !req_full
//   response  rsp_pop, rsp_empty, rsp_data            rsp_pop && !rsp_empty
//   csr       csr_write_en, csr_index, csr_write_data csr_write_en
//
// Bytes hash at one per cycle unless the job queue is full; a final byte queues a lookup
// job (queue depth 2). A lookup scans the table RAM one entry per cycle, through every
// entry on a miss and stopping at the match on a hit, behind the registered RAM read.
// Reset clears the valid bits at once; no clearing pass.
// The front stalls only while the job queue is full; the back end holds its result
// until popped and may scan the next job meanwhile.
`timescale 1ns / 1ps
module fingerprint_param_tuner_core
   import fpt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  req_payload_type req_data,
   input  logic rsp_pop,
   output logic rsp_empty,
   output rsp_payload_type rsp_data,
   input  logic csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type cfg_ff, cfg_in;
   logic job_push;
   logic job_full;
   logic job_pop;
   logic job_empty;
   job_type push_job;
   job_type head_job;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_RECALL_LOW: cfg_in.recall_low = csr_write_data;
            REG_RECALL_HIGH: cfg_in.recall_high = csr_write_data;
            REG_LATENCY_HIGH: cfg_in.latency_high = csr_write_data[15:0];
            REG_LATENCY_LOW: cfg_in.latency_low = csr_write_data[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.recall_low <= RECALL_LOW_RESET;
         cfg_ff.recall_high <= RECALL_HIGH_RESET;
         cfg_ff.latency_high <= LATENCY_HIGH_RESET;
         cfg_ff.latency_low <= LATENCY_LOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fpt_hash u_hash (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_data(req_data),
      .queue_full(job_full),
      .job_push(job_push),
      .job_data(push_job)
   );

   fpt_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(job_push),
      .push_data(push_job),
      .pop(job_pop),
      .full(job_full),
      .empty(job_empty),
      .head(head_job)
   );

   fpt_table u_table (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .job_empty(job_empty),
      .job_head(head_job),
      .job_pop(job_pop),
      .rsp_pop(rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_data(rsp_data)
   );

   assign req_full = job_full;

endmodule

>>> src/fpt_checker.sv
// Port-level assertions for the fingerprint parameter tuner, bound to the top level.
`timescale 1ns / 1ps
module fpt_checker
   import fpt_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_full,
   input logic rsp_pop,
   input logic rsp_empty,
   input rsp_payload_type rsp_data
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting response changed");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.table_full) |->
         (!rsp_data.was_found && rsp_data.times_seen == 32'd0 &&
          rsp_data.search_breadth == EF_DEFAULT && rsp_data.beam_width == BEAM_DEFAULT))
      else $error("table full result malformed");

   a_insert_result: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.table_full && !rsp_data.was_found) |->
         (rsp_data.times_seen == 32'd1 && rsp_data.search_breadth == EF_DEFAULT &&
          rsp_data.beam_width == BEAM_DEFAULT))
      else $error("insert result malformed");

   a_ranges: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.was_found) |->
         (!rsp_data.table_full && rsp_data.times_seen != 32'd0 &&
          rsp_data.search_breadth >= 9'd8 && rsp_data.search_breadth <= 9'd256 &&
          rsp_data.beam_width >= 7'd2 && rsp_data.beam_width <= 7'd64))
      else $error("hit result out of range");

endmodule

bind fingerprint_param_tuner_core fpt_checker u_checker (.*);

>>> test/testbench.sv
// Self-checking testbench for fingerprint_param_tuner_core: directed and random queries, predicted results.
`timescale 1ns / 1ps
module testbench;
   import fpt_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_BYTES = 110;

   class tuner_scoreboard;
      logic [63:0] hash_acc;
      bit          slot_valid [TABLE_ENTRIES];
      logic [63:0] slot_key   [TABLE_ENTRIES];
      logic [31:0] slot_seen  [TABLE_ENTRIES];
      logic [8:0]  slot_ef    [TABLE_ENTRIES];
      logic [6:0]  slot_beam  [TABLE_ENTRIES];
      logic [16:0] recall_lo;
      logic [16:0] recall_hi;
      logic [15:0] latency_hi;
      logic [15:0] latency_lo;
      rsp_payload_type expected_q[$];
      int errors;

      function new();
         hash_acc = HASH_SEED;
         foreach (slot_valid[i]) slot_valid[i] = 1'b0;
         recall_lo = RECALL_LOW_RESET;
         recall_hi = RECALL_HIGH_RESET;
         latency_hi = LATENCY_HIGH_RESET;
         latency_lo = LATENCY_LOW_RESET;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            REG_RECALL_LOW: recall_lo = value;
            REG_RECALL_HIGH: recall_hi = value;
            REG_LATENCY_HIGH: latency_hi = value[15:0];
            REG_LATENCY_LOW: latency_lo = value[15:0];
            default: ;
         endcase
      endfunction

      // fold one accepted byte; a final byte yields one expected transaction
      function void note_byte(req_payload_type item);
         rsp_payload_type res;
         int hit;
         int free_slot;
         int i;
         logic [9:0] ef;
         logic [7:0] beam;
         hash_acc = (hash_acc << 5) + hash_acc + 64'(item.text_byte);
         if (!item.last_byte) return;
         res.fingerprint = hash_acc;
         hash_acc = HASH_SEED;
         hit = -1;
         free_slot = -1;
         for (i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_valid[i]) begin
               if (hit < 0 && slot_key[i] == res.fingerprint) hit = i;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         res.was_found = 1'b0;
         res.table_full = 1'b0;
         res.times_seen = '0;
         ef = 10'(EF_DEFAULT);
         beam = 8'(BEAM_DEFAULT);
         if (hit >= 0) begin
            res.was_found = 1'b1;
            res.times_seen = (slot_seen[hit] == '1) ? slot_seen[hit] : slot_seen[hit] + 32'd1;
            ef = {1'b0, slot_ef[hit]};
            beam = {1'b0, slot_beam[hit]};
            if (item.recall < recall_lo && ef < EF_GROW_BELOW) ef = ef + EF_STEP;
            if (item.recall > recall_hi && ef > EF_SHRINK_ABOVE) ef = ef - EF_STEP;
            if (item.latency > latency_hi && beam > BEAM_SHRINK_ABOVE) begin
               beam = beam - BEAM_STEP;
            end else if (item.latency < latency_lo && beam < BEAM_GROW_BELOW) begin
               beam = beam + BEAM_STEP;
            end
            if (ef < EF_MIN) ef = EF_MIN;
            if (ef > EF_MAX) ef = EF_MAX;
            if (beam < BEAM_MIN) beam = BEAM_MIN;
            if (beam > BEAM_MAX) beam = BEAM_MAX;
            slot_seen[hit] = res.times_seen;
            slot_ef[hit] = ef[8:0];
            slot_beam[hit] = beam[6:0];
         end else if (free_slot >= 0) begin
            res.times_seen = 32'd1;
            slot_valid[free_slot] = 1'b1;
            slot_key[free_slot] = res.fingerprint;
            slot_seen[free_slot] = 32'd1;
            slot_ef[free_slot] = ef[8:0];
            slot_beam[free_slot] = beam[6:0];
         end else begin
            res.table_full = 1'b1;
         end
         res.search_breadth = ef[8:0];
         res.beam_width = beam[6:0];
         expected_q.push_back(res);
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= 20)
               $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 20)
               $display("%0t: unexpected transaction, expected none, actual fingerprint %0h",
                        $time, got.fingerprint);
            return;
         end
         want = expected_q.pop_front();
         check_field("fingerprint", want.fingerprint, got.fingerprint);
         check_field("was_found", 64'(want.was_found), 64'(got.was_found));
         check_field("table_full", 64'(want.table_full), 64'(got.table_full));
         check_field("times_seen", 64'(want.times_seen), 64'(got.times_seen));
         check_field("search_breadth", 64'(want.search_breadth), 64'(got.search_breadth));
         check_field("beam_width", 64'(want.beam_width), 64'(got.beam_width));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_push;
   logic req_full;
   req_payload_type req_data;
   logic rsp_pop;
   logic rsp_empty;
   rsp_payload_type rsp_data;
   logic csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   tuner_scoreboard scoreboard = new();
   bit sender_quiet = 1'b0;
   bit receiver_quiet = 1'b0;
   bit hold_request = 1'b0;
   int stall_cycles = 0;
   int bytes_sent = 0;
   logic [63:0] query_text[$];
   int query_len[$];

   fingerprint_param_tuner_core u_top (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .rsp_pop(rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_write_en) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic push_item(req_payload_type item);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      scoreboard.note_byte(item);
      bytes_sent++;
   endtask

   // bytes go out lowest first; off-last bytes carry noise in recall and latency
   task automatic send_query(logic [63:0] text, int len, logic [16:0] recall,
                             logic [15:0] latency);
      req_payload_type item;
      int i;
      for (i = 0; i < len; i++) begin
         item.text_byte = text[8*i +: 8];
         item.last_byte = (i == len - 1);
         item.recall = (i == len - 1) ? recall : 17'($urandom);
         item.latency = (i == len - 1) ? latency : 16'($urandom);
         push_item(item);
      end
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      scoreboard.write_reg(index, value);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (scoreboard.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(int phase);
      logic [16:0] rlo;
      logic [16:0] rhi;
      logic [15:0] lhi;
      logic [15:0] llo;
      case (phase)
         0: begin rlo = 17'd0;      rhi = 17'd65536;  lhi = 16'd0;     llo = 16'd65535; end
         1: begin rlo = 17'd65536;  rhi = 17'd0;      lhi = 16'd65535; llo = 16'd0;     end
         2: begin rlo = 17'd131071; rhi = 17'd131071; lhi = 16'd50;    llo = 16'd50;    end
         3: begin
            rlo = 17'($urandom_range(0, 65536));
            rhi = 17'($urandom_range(0, 65536));
            lhi = 16'($urandom);
            llo = 16'($urandom);
         end
         default: begin
            rlo = RECALL_LOW_RESET;
            rhi = RECALL_HIGH_RESET;
            lhi = LATENCY_HIGH_RESET;
            llo = LATENCY_LOW_RESET;
         end
      endcase
      csr_write(REG_RECALL_LOW, rlo);
      csr_write(REG_RECALL_HIGH, rhi);
      csr_write(REG_LATENCY_HIGH, {1'($urandom), lhi});
      csr_write(REG_LATENCY_LOW, {1'($urandom), llo});
      csr_write(CSR_INDEX_W'($urandom_range(4, 15)), CSR_DATA_W'($urandom));
   endtask

   function automatic logic [16:0] pick_recall();
      case ($urandom_range(0, 6))
         0: return 17'($urandom);
         1: return 17'd0;
         2: return 17'd65536;
         3: return scoreboard.recall_lo + 17'($urandom_range(0, 2)) - 17'd1;
         4: return scoreboard.recall_hi + 17'($urandom_range(0, 2)) - 17'd1;
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic [15:0] pick_latency();
      case ($urandom_range(0, 6))
         0: return 16'($urandom);
         1: return 16'd0;
         2: return 16'd65535;
         3: return scoreboard.latency_hi + 16'($urandom_range(0, 2)) - 16'd1;
         4: return scoreboard.latency_lo + 16'($urandom_range(0, 2)) - 16'd1;
         default: return 16'($urandom_range(0, 200));
      endcase
   endfunction

   initial begin
      int gap;
      rsp_pop <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            gap = receiver_quiet ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
               rsp_pop <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         scoreboard.check_result(rsp_data);
      end
   end

   initial begin
      int phase;
      int phase_start;
      int new_pct;
      int pick;
      int idx;
      int len;
      logic [63:0] text;
      reset <= 1'b1;
      req_push <= 1'b0;
      req_data <= '0;
      csr_write_en <= 1'b0;
      csr_index <= '0;
      csr_write_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero byte, repeat hits, exact thresholds, all-ones text
      send_query(64'h00, 1, 17'd0, 16'd0);
      send_query(64'h00, 1, 17'd0, 16'd0);
      send_query(64'h00, 1, 17'd65536, 16'd65535);
      send_query(64'h00FF, 2, 17'd131071, 16'd65535);
      send_query(64'h00FF, 2, 17'd131071, 16'd65535);
      send_query(64'h00, 1, RECALL_LOW_RESET, LATENCY_HIGH_RESET);
      send_query(64'h00, 1, RECALL_LOW_RESET - 17'd1, LATENCY_LOW_RESET - 16'd1);
      send_query('1, 8, RECALL_HIGH_RESET, LATENCY_LOW_RESET);
      send_query('1, 8, RECALL_HIGH_RESET + 17'd1, LATENCY_HIGH_RESET + 16'd1);
      query_text = '{64'h00, 64'h00FF, '1};
      query_len = '{1, 2, 8};
      drain();

      for (phase = 0; phase < 5; phase++) begin
         configure(phase);
         sender_quiet = phase[0];
         receiver_quiet = phase[1];
         new_pct = (phase == 4) ? 60 : 35;
         if (phase == 1) hold_request = 1'b1;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            if ($urandom_range(0, 15) == 0) sender_quiet = ~sender_quiet;
            if ($urandom_range(0, 15) == 0) receiver_quiet = ~receiver_quiet;
            pick = $urandom_range(0, 99);
            if (pick < new_pct) begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
               text = {$urandom, $urandom};
               query_text.push_back(text);
               query_len.push_back(len);
            end else begin
               if (pick < new_pct + (100 - new_pct) / 2)
                  idx = $urandom_range(0, (query_text.size() < 4) ? query_text.size() - 1 : 3);
               else
                  idx = $urandom_range(0, query_text.size() - 1);
               text = query_text[idx];
               len = query_len[idx];
            end
            send_query(text, len, pick_recall(), pick_latency());
         end
         drain();
      end

      if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
